>>> rtl/interval_table_merge_lookup_assert.svh
// ---------------------------------------------------------------------------
// Interval table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef INTERVAL_TABLE_MERGE_LOOKUP_ASSERT_SVH
`define INTERVAL_TABLE_MERGE_LOOKUP_ASSERT_SVH

// A condition that must hold at every clock edge.
`define ITML_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define ITML_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/itml_pkg.sv
// ---------------------------------------------------------------------------
// Interval table package
// Sizes, codes and the entry record shared by the table and its store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itml_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int OFFSET_BITS = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ALIGN_W     = 3;

  // Beat widths: fields packed from bit 0, padded to whole bytes.
  localparam int IN_BITS  = 2 * OFFSET_BITS + ALIGN_W + 2;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + OFFSET_BITS + (OFFSET_BITS + 1) + ALIGN_W + 1 + CNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_INSERT = 2'd1,
    FN_LOOKUP = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISALIGN = 2'd1,
    ST_FULL     = 2'd2,
    ST_SPAN     = 2'd3
  } status_t;

  // One stored range.
  typedef struct packed {
    logic                   danger;
    logic [ALIGN_W-1:0]     align;
    logic [OFFSET_BITS:0]   length;
    logic [OFFSET_BITS-1:0] start;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/itml_ram.sv
// ---------------------------------------------------------------------------
// Interval table entry store
// One write port and one registered read port over the range records.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itml_ram (
  input  wire                         clk,
  input  wire                         we,
  input  wire  [itml_pkg::IDX_W-1:0]  waddr,
  input  itml_pkg::entry_t            wdata,
  input  wire  [itml_pkg::IDX_W-1:0]  raddr,
  output itml_pkg::entry_t            rdata
);
  import itml_pkg::*;

  entry_t mem [TABLE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/interval_table_merge_lookup.sv
// ---------------------------------------------------------------------------
// Interval table with overlap merging and point lookup
// Keeps non-overlapping byte ranges, merges overlaps on insert and finds the
// range holding an offset on lookup.
// ---------------------------------------------------------------------------
// Use: one command beat enters on s_axis (tuser carries the function code,
// tdata the offset, size, alignment and flags) and one result beat leaves on
// m_axis (tuser carries the status, tdata the found entry and the count).
// A clear, an unused code or an insert whose span is out of range goes
// straight from acceptance to the finish state and the result register.
// An insert or a lookup first walks the entry store once, one entry a
// cycle through its registered read port. One command is in work at a
// time: s_axis_tready is high only while the sequencer is idle. The
// result register lets the next command be taken while a result waits; a
// stalled receiver only holds up the end of that next command. Reset
// clears every valid bit, the count and m_axis_tvalid, and returns the
// sequencer to idle; the store itself is not cleared and needs no pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module interval_table_merge_lookup (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  // range_offset, range_size, align_log2, mark_dangerous, exact_match, pad
  input  wire  [itml_pkg::IN_W-1:0]   s_axis_tdata,
  // func
  input  wire  [1:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  // hit, found_offset, found_size, found_align_log2, found_dangerous,
  // entry_count, pad
  output logic [itml_pkg::OUT_W-1:0]  m_axis_tdata,
  // status
  output logic [1:0]                  m_axis_tuser
);
  import itml_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t                 state;
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [CNT_W-1:0]       valid_count;

  // Command registers.
  func_t                  op_func;
  logic [OFFSET_BITS-1:0] op_off;
  logic [OFFSET_BITS:0]   op_end;
  logic [ALIGN_W-1:0]     op_al;
  logic                   op_dang;
  logic                   op_exact;
  logic                   op_span;

  // Scan sequencer.
  logic [CNT_W-1:0]       issue_cnt;
  logic                   rd_pend;
  logic [IDX_W-1:0]       rd_idx;
  entry_t                 rd_entry;

  // Merge accumulators.
  logic [TABLE_DEPTH-1:0] ov_vec;
  logic [CNT_W-1:0]       m_cnt;
  logic                   m_any;
  logic [OFFSET_BITS-1:0] min_start;
  logic [OFFSET_BITS:0]   max_end;
  logic [ALIGN_W-1:0]     al_all;
  logic [ALIGN_W-1:0]     al_excl;
  logic [ALIGN_W-1:0]     al_low;
  logic [IDX_W-1:0]       first_free;
  logic                   free_found;

  // Lookup accumulators.
  logic                   lk_hit;
  entry_t                 lk_entry;

  // Result register.
  logic                   out_valid;
  status_t                o_status;
  logic                   o_hit;
  entry_t                 o_entry;
  logic [CNT_W-1:0]       o_count;

  function automatic logic [ALIGN_W-1:0] amax(input logic [ALIGN_W-1:0] a,
                                              input logic [ALIGN_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] amask(input logic [ALIGN_W-1:0] al);
    return ~({OFFSET_BITS{1'b1}} << al);
  endfunction

  // Decode of the incoming beat.
  logic                   in_beat;
  logic [OFFSET_BITS-1:0] in_off;
  logic [OFFSET_BITS-1:0] in_size_raw;
  logic [OFFSET_BITS:0]   in_size;
  logic [OFFSET_BITS:0]   in_end;
  logic                   in_zero;

  assign s_axis_tready = (state == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign in_off        = s_axis_tdata[OFFSET_BITS-1:0];
  assign in_size_raw   = s_axis_tdata[2*OFFSET_BITS-1:OFFSET_BITS];
  assign in_zero       = (in_size_raw == '0);
  assign in_size       = in_zero ? (OFFSET_BITS+1)'(1) : {1'b0, in_size_raw};
  assign in_end        = {1'b0, in_off} + in_size;

  // Overlap and containment tests on the entry being read back.
  logic                   rd_v;
  logic [OFFSET_BITS:0]   rd_eend;
  logic                   rd_ov;
  logic                   rd_in;

  assign rd_v    = entry_valid[rd_idx];
  assign rd_eend = {1'b0, rd_entry.start} + rd_entry.length;
  assign rd_ov   = rd_v && ({1'b0, rd_entry.start} < op_end) && (rd_eend > {1'b0, op_off});
  assign rd_in   = rd_v && (op_off >= rd_entry.start) && ({1'b0, op_off} < rd_eend);

  // Final insert decision.
  logic                   can_fin;
  logic [OFFSET_BITS-1:0] f_start;
  logic                   f_misal;
  logic [CNT_W:0]         f_cnt;
  logic                   f_full;
  logic                   commit_ok;
  entry_t                 f_entry;

  always_comb begin
    can_fin   = (state == S_FINISH) && (!out_valid || m_axis_tready);
    f_start   = (m_any && (min_start < op_off)) ? min_start : op_off;
    f_misal   = ((m_cnt > CNT_W'(1)) && ((op_off & amask(al_excl)) != '0)) ||
                (m_any && ((f_start & amask(al_all)) != '0));
    f_cnt     = {1'b0, valid_count} - {1'b0, m_cnt} + (CNT_W+1)'(1);
    f_full    = (f_cnt > (CNT_W+1)'(TABLE_DEPTH));
    commit_ok = can_fin && (op_func == FN_INSERT) && !op_span && !f_misal && !f_full;
    f_entry.start  = f_start;
    f_entry.length = max_end - {1'b0, f_start};
    f_entry.align  = al_all;
    f_entry.danger = op_dang || m_any;
  end

  // Entry store.
  itml_ram u_ram (
    .clk   (clk),
    .we    (commit_ok),
    .waddr (first_free),
    .wdata (f_entry),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  // Sequencer, accumulators and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      valid_count <= '0;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
    end else begin
      if (can_fin) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            op_func    <= func_t'(s_axis_tuser);
            op_off     <= in_off;
            op_end     <= in_end;
            op_al      <= s_axis_tdata[2*OFFSET_BITS+ALIGN_W-1:2*OFFSET_BITS];
            op_dang    <= s_axis_tdata[2*OFFSET_BITS+ALIGN_W] || in_zero;
            op_exact   <= s_axis_tdata[2*OFFSET_BITS+ALIGN_W+1];
            op_span    <= in_end[OFFSET_BITS] && (in_end[OFFSET_BITS-1:0] != '0);
            issue_cnt  <= '0;
            rd_pend    <= 1'b0;
            ov_vec     <= '0;
            m_cnt      <= '0;
            m_any      <= 1'b0;
            max_end    <= in_end;
            al_all     <= s_axis_tdata[2*OFFSET_BITS+ALIGN_W-1:2*OFFSET_BITS];
            al_excl    <= s_axis_tdata[2*OFFSET_BITS+ALIGN_W-1:2*OFFSET_BITS];
            free_found <= 1'b0;
            lk_hit     <= 1'b0;
            if ((func_t'(s_axis_tuser) == FN_LOOKUP) ||
                ((func_t'(s_axis_tuser) == FN_INSERT) &&
                 !(in_end[OFFSET_BITS] && (in_end[OFFSET_BITS-1:0] != '0)))) begin
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          // Issue one read a cycle.
          if (issue_cnt != CNT_W'(TABLE_DEPTH)) begin
            rd_pend   <= 1'b1;
            rd_idx    <= issue_cnt[IDX_W-1:0];
            issue_cnt <= issue_cnt + CNT_W'(1);
          end else begin
            rd_pend <= 1'b0;
          end
          // Fold in the entry read last cycle.
          if (rd_pend) begin
            if (rd_ov) begin
              ov_vec[rd_idx] <= 1'b1;
              m_cnt          <= m_cnt + CNT_W'(1);
              m_any          <= 1'b1;
              max_end        <= (rd_eend > max_end) ? rd_eend : max_end;
              al_all         <= amax(al_all, rd_entry.align);
              if (!m_any || (rd_entry.start < min_start)) begin
                if (m_any) begin
                  al_excl <= amax(al_excl, al_low);
                end
                min_start <= rd_entry.start;
                al_low    <= rd_entry.align;
              end else begin
                al_excl <= amax(al_excl, rd_entry.align);
              end
            end
            if ((!rd_v || rd_ov) && !free_found) begin
              first_free <= rd_idx;
              free_found <= 1'b1;
            end
            if (rd_in && (!op_exact || (rd_entry.start == op_off))) begin
              lk_hit   <= 1'b1;
              lk_entry <= rd_entry;
            end
            if (rd_idx == IDX_W'(TABLE_DEPTH - 1)) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (can_fin) begin
            state <= S_IDLE;
            case (op_func)
              FN_CLEAR: begin
                entry_valid <= '0;
                valid_count <= '0;
                o_status    <= ST_OK;
                o_hit       <= 1'b0;
                o_entry     <= '0;
                o_count     <= '0;
              end
              FN_INSERT: begin
                o_hit <= 1'b0;
                if (op_span) begin
                  o_status <= ST_SPAN;
                  o_entry  <= '0;
                  o_count  <= valid_count;
                end else if (f_misal) begin
                  o_status <= ST_MISALIGN;
                  o_entry  <= '0;
                  o_count  <= valid_count;
                end else if (f_full) begin
                  o_status <= ST_FULL;
                  o_entry  <= '0;
                  o_count  <= valid_count;
                end else begin
                  entry_valid <= (entry_valid & ~ov_vec) |
                                 (TABLE_DEPTH'(1) << first_free);
                  valid_count <= f_cnt[CNT_W-1:0];
                  o_status    <= ST_OK;
                  o_count     <= f_cnt[CNT_W-1:0];
                  o_entry     <= f_entry;
                end
              end
              FN_LOOKUP: begin
                o_status <= ST_OK;
                o_hit    <= lk_hit;
                o_entry  <= lk_hit ? lk_entry : '0;
                o_count  <= valid_count;
              end
              default: begin
                o_status <= ST_OK;
                o_hit    <= 1'b0;
                o_entry  <= '0;
                o_count  <= valid_count;
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result beat.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = o_status;
  assign m_axis_tdata  = OUT_W'({o_count, o_entry.danger, o_entry.align,
                                 o_entry.length, o_entry.start, o_hit});

  // Checks on the table bookkeeping.
  `include "interval_table_merge_lookup_assert.svh"

  `ITML_ASSERT_ALWAYS(a_count_matches, valid_count == CNT_W'($countones(entry_valid)), "count differs from valid bits")
  `ITML_ASSERT_ALWAYS(a_count_bound, valid_count <= CNT_W'(TABLE_DEPTH), "count beyond table depth")
  `ITML_ASSERT_NEXT(a_slot_set, commit_ok, entry_valid[first_free], "written slot not valid")

endmodule

`default_nettype wire
